>>> rtl/tmq_pkg.sv
// Package for the typed message queue: opcodes, status codes and sequencer states.
// No dependencies.
package tmq_pkg;

    localparam int TypeBits = 15;
    localparam int SelBits  = 16;
    localparam int SizeBits = 12;
    localparam int StatBits = 3;

    // Request opcodes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_TOO_SMALL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_LINK,
        S_WALK,
        S_CHECK,
        S_UNLINK,
        S_DONE
    } t_state;

endpackage

>>> rtl/tmq_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface tmq_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/typed_message_queue_selective_pop_top.sv
// Top level of the typed message queue with type-selective pop.
// Depends on tmq_pkg and tmq_if.
//
// The block takes one request at a time. A push scans the free map one slot
// per cycle from slot 0 for the lowest free slot and links it at the tail; a
// full store answers once the scan has passed every slot, and a push of size
// zero answers without scanning. A pop walks the list from the head, reading
// one slot per cycle through a single shared type compare, and takes the first
// match; a pop with no match answers when the walk reaches the end of the
// list. Slot memory is unreset; the walk only follows slots that a push has
// linked. The result sits in an output register, and the next request can be
// accepted at the edge after the result is taken.
// Input data packs {opcode, msg_type, selector, payload, size}, MSB first;
// output data packs {status, out_type, out_payload, out_size}.
module typed_message_queue_selective_pop_top #(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tmq_if.sink   i_req,
    tmq_if.source o_rsp
);
    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);
    localparam int TB = tmq_pkg::TypeBits;
    localparam int ZB = tmq_pkg::SizeBits;

    // Unpack the request.
    logic            in_op;
    logic [TB-1:0]   in_type;
    logic signed [tmq_pkg::SelBits-1:0] in_sel;
    logic [31:0]     in_pay;
    logic [ZB-1:0]   in_size;
    assign {in_op, in_type, in_sel, in_pay, in_size} = i_req.data;

    // Slot memories.
    logic [TB-1:0]           m_type [SLOTS];
    logic [PAYLOAD_BITS-1:0] m_pay  [SLOTS];
    logic [ZB-1:0]           m_size [SLOTS];
    logic [LW-1:0]           m_next [SLOTS];
    logic [LW-1:0]           m_prev [SLOTS];

    tmq_pkg::t_state r_state, n_state;
    logic [SLOTS-1:0] r_free;
    logic [LW-1:0]    r_head, r_tail, r_cur, n_cur;
    logic [LW-1:0]    r_cnt;
    logic [TB-1:0]    r_ty;
    logic signed [tmq_pkg::SelBits-1:0] r_sel;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [ZB-1:0]    r_sz;
    logic             r_ovalid;
    logic [2:0]       r_ost;
    logic [TB-1:0]    r_otype;
    logic [31:0]      r_opay;
    logic [ZB-1:0]    r_osize;

    // Registered read of the slot under the walk pointer.
    logic [TB-1:0]           r_ctype;
    logic [PAYLOAD_BITS-1:0] r_cpay;
    logic [ZB-1:0]           r_csize;
    logic [LW-1:0]           r_cnext;
    logic [LW-1:0]           r_cprev;

    logic [IW-1:0] cur_i;
    logic [IW-1:0] n_cur_i;
    assign cur_i   = r_cur[IW-1:0];
    assign n_cur_i = n_cur[IW-1:0];

    // Shared type compare against the slot under the walk pointer.
    logic          match;
    logic [16:0]   mag;
    assign mag = 17'(-$signed({r_sel[15], r_sel}));
    always_comb begin
        if (r_sel == 16'sd0) match = 1'b1;
        else if (!r_sel[15]) match = ({1'b0, r_sel[14:0]} == {1'b0, r_ctype});
        else match = ({2'b0, r_ctype} <= mag);
    end

    assign i_req.ready = (r_state == tmq_pkg::S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = {r_ost, r_otype, r_opay, r_osize};

    // Next state and next walk pointer.
    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        case (r_state)
            tmq_pkg::S_IDLE:
                if (i_req.valid && i_req.ready) begin
                    if (in_op == tmq_pkg::OP_POP) begin
                        n_state = tmq_pkg::S_WALK;
                        n_cur   = r_head;
                    end else begin
                        n_state = tmq_pkg::S_ALLOC;
                        n_cur   = '0;
                    end
                end
            tmq_pkg::S_ALLOC:
                if (r_sz == '0 || r_cnt == NIL) n_state = tmq_pkg::S_DONE;
                else if (r_free[cur_i]) n_state = tmq_pkg::S_LINK;
                else n_cur = r_cur + 1'b1;
            tmq_pkg::S_LINK:   n_state = tmq_pkg::S_DONE;
            tmq_pkg::S_WALK:
                if (r_cur >= NIL || r_cnt == NIL) n_state = tmq_pkg::S_DONE;
                else if (match) n_state = tmq_pkg::S_CHECK;
                else n_cur = r_cnext;
            tmq_pkg::S_CHECK:
                if (r_sz != '0 && r_sz < r_csize) n_state = tmq_pkg::S_DONE;
                else n_state = tmq_pkg::S_UNLINK;
            tmq_pkg::S_UNLINK: n_state = tmq_pkg::S_DONE;
            tmq_pkg::S_DONE:   n_state = tmq_pkg::S_IDLE;
            default:           n_state = tmq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tmq_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // Walk pointer and the slot read at the address it moves to.
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_ctype <= m_type[n_cur_i];
        r_cpay  <= m_pay[n_cur_i];
        r_csize <= m_size[n_cur_i];
        r_cnext <= m_next[n_cur_i];
        r_cprev <= m_prev[n_cur_i];
    end

    // Datapath, control registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '1;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_ovalid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                tmq_pkg::S_IDLE:
                    if (i_req.valid && i_req.ready) begin
                        r_ty  <= in_type;
                        r_sel <= in_sel;
                        r_pay <= PAYLOAD_BITS'({32'b0, in_pay});
                        r_sz  <= in_size;
                        r_cnt <= '0;
                        r_ost <= tmq_pkg::ST_OK;
                        r_otype <= '0;
                        r_opay  <= '0;
                        r_osize <= '0;
                    end
                tmq_pkg::S_ALLOC:
                    if (r_sz == '0) r_ost <= tmq_pkg::ST_BAD_SIZE;
                    else if (r_cnt == NIL) r_ost <= tmq_pkg::ST_FULL;
                    else if (!r_free[cur_i]) r_cnt <= r_cnt + 1'b1;
                    else m_next[cur_i] <= NIL;
                tmq_pkg::S_LINK: begin
                    r_free[cur_i] <= 1'b0;
                    m_type[cur_i] <= r_ty;
                    m_pay[cur_i]  <= r_pay;
                    m_size[cur_i] <= r_sz;
                    m_prev[cur_i] <= r_tail;
                    if (r_tail < NIL) m_next[r_tail[IW-1:0]] <= r_cur;
                    else r_head <= r_cur;
                    r_tail <= r_cur;
                end
                tmq_pkg::S_WALK:
                    if (r_cur >= NIL || r_cnt == NIL) r_ost <= tmq_pkg::ST_NOT_FOUND;
                    else if (!match) r_cnt <= r_cnt + 1'b1;
                tmq_pkg::S_CHECK:
                    if (r_sz != '0 && r_sz < r_csize) begin
                        r_ost   <= tmq_pkg::ST_TOO_SMALL;
                        r_osize <= r_csize;
                    end else begin
                        r_otype <= r_ctype;
                        r_opay  <= 32'({32'b0, r_cpay});
                        r_osize <= r_csize;
                    end
                tmq_pkg::S_UNLINK: begin
                    if (r_cprev < NIL) m_next[r_cprev[IW-1:0]] <= r_cnext;
                    else r_head <= r_cnext;
                    if (r_cnext < NIL) m_prev[r_cnext[IW-1:0]] <= r_cprev;
                    else r_tail <= r_cprev;
                    r_free[cur_i] <= 1'b1;
                end
                tmq_pkg::S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule
